// File: sv/ccs_pkg.sv
// Shared types, constants and functions for the cave column step unit.
`default_nettype none

package ccs_pkg;

   // Width of the column ports; the number of live rows is a parameter up to this.
   localparam int COLUMN_WIDTH        = 64;
   localparam int COLUMN_BITS_DEFAULT = 64;

   // Threshold register
   localparam int          THRESHOLD_WIDTH = 4;
   localparam logic [3:0]  THRESHOLD_RESET = 4'd5;

   // Taps of one row across the window: left, centre, right
   localparam int TAP_WIDTH  = 3;
   localparam int TAP_LEFT   = 2;
   localparam int TAP_CENTRE = 1;
   localparam int TAP_RIGHT  = 0;

   // Cells in a 3x3 block
   localparam int BLOCK_CELLS = 9;

   typedef logic [1:0] fill_type;
   localparam fill_type FILL_EMPTY = 2'd0;
   localparam fill_type FILL_FULL  = 2'd2;

   // Control broadcast from the top level to every row cell
   typedef struct packed {
      logic                       shift;
      logic                       load_result;
      logic [THRESHOLD_WIDTH-1:0] threshold;
   } cell_ctrl_type;

   // Count the walls in a 3x3 block
   function automatic logic [THRESHOLD_WIDTH-1:0] count_walls(
      input logic [BLOCK_CELLS-1:0] block
   );
      logic [THRESHOLD_WIDTH-1:0] total;
      total = '0;
      for (int i = 0; i < BLOCK_CELLS; i++) begin
         total = total + {{(THRESHOLD_WIDTH-1){1'b0}}, block[i]};
      end
      return total;
   endfunction

endpackage

`default_nettype wire

// File: sv/cave_ca_column_step_unit.sv
// Top level of the cave cellular automaton column step unit.
//
// Usage
//   A chunk streams in on the req_ channel as one column per transfer: a left
//   boundary column, the chunk columns, then a right boundary column flagged
//   with req_last_column. Each column brings the seam bits from the chunks
//   above and below; the feeder supplies walls where no neighbour exists.
//   Once two columns sit in the window, each further column yields one
//   updated centre column on the rsp_ channel; rsp_last marks the result of
//   the flagged column, after which the window starts empty again.
//   A result appears in the cycle after the column that completes it.
//   One column per cycle while the receiver keeps up, as the row of cells
//   shifts and counts each column at once; the output register lets the next
//   column enter while a result is being taken.
//   When the receiver stalls, the result holds in the cells' output bits and
//   req_ready drops until it is taken.
//   Reset empties the window and the output, and sets the threshold to five.
//   csr_write_data is the wall threshold, written when csr_write_enable is high.
`default_nettype none

module cave_ca_column_step_unit #(
   parameter int COLUMN_BITS = ccs_pkg::COLUMN_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // column input
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [ccs_pkg::COLUMN_WIDTH-1:0]       req_column_bits,
   input  wire logic                                   req_seam_above,
   input  wire logic                                   req_seam_below,
   input  wire logic                                   req_last_column,
   // result output
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic      [ccs_pkg::COLUMN_WIDTH-1:0]       rsp_next_column,
   output logic                                        rsp_last,
   // threshold register
   input  wire logic                                   csr_write_enable,
   input  wire logic [ccs_pkg::THRESHOLD_WIDTH-1:0]    csr_write_data
);

   logic [ccs_pkg::THRESHOLD_WIDTH-1:0] threshold_ff, threshold_in;
   ccs_pkg::fill_type                   fill_ff, fill_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_last_ff, rsp_last_in;
   // seam bits of the window's left and centre columns
   logic [1:0]                          above_ff, above_in;
   logic [1:0]                          below_ff, below_in;

   logic                                accept;
   logic                                produce;
   ccs_pkg::cell_ctrl_type              cell_ctrl;

   // taps per row, seam above at index 0 and seam below at COLUMN_BITS+1
   logic [ccs_pkg::TAP_WIDTH-1:0]       row_taps [COLUMN_BITS+2];
   logic [1:0]                          cell_window [COLUMN_BITS];
   logic [COLUMN_BITS-1:0]              cell_result;

   // take a column whenever the output register is free or being emptied
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign produce   = accept && (fill_ff == ccs_pkg::FILL_FULL);

   always_comb begin
      threshold_in = csr_write_enable ? csr_write_data : threshold_ff;

      fill_in = fill_ff;
      if (accept) begin
         // drop the window after the closing column
         if (req_last_column) begin
            fill_in = ccs_pkg::FILL_EMPTY;
         end else if (fill_ff != ccs_pkg::FILL_FULL) begin
            fill_in = fill_ff + 2'd1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      if (produce) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = req_last_column;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      above_in = above_ff;
      below_in = below_ff;
      if (accept) begin
         above_in = {above_ff[0], req_seam_above};
         below_in = {below_ff[0], req_seam_below};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ccs_pkg::THRESHOLD_RESET;
         fill_ff      <= ccs_pkg::FILL_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_last_ff <= rsp_last_in;
      above_ff    <= above_in;
      below_ff    <= below_in;
   end

   assign cell_ctrl.shift       = accept;
   assign cell_ctrl.load_result = produce;
   assign cell_ctrl.threshold   = threshold_ff;

   // seam rows at both ends of the chain
   assign row_taps[0]             = {above_ff, req_seam_above};
   assign row_taps[COLUMN_BITS+1] = {below_ff, req_seam_below};

   // chain of row cells, each seeing its neighbours' taps
   for (genvar z = 0; z < COLUMN_BITS; z++) begin : g_row
      assign row_taps[z+1] = {cell_window[z], req_column_bits[z]};

      ccs_row_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .up_taps    (row_taps[z]),
         .down_taps  (row_taps[z+2]),
         .right_bit  (req_column_bits[z]),
         .own_taps   (cell_window[z]),
         .result_bit (cell_result[z])
      );
   end

   // rows above COLUMN_BITS read as open
   always_comb begin
      rsp_next_column                  = '0;
      rsp_next_column[COLUMN_BITS-1:0] = cell_result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

// File: sv/ccs_row_cell.sv
// One row cell: holds its row's two window bits and the row's result bit.
`default_nettype none

module ccs_row_cell (
   input  wire logic                                  clock,
   input  wire ccs_pkg::cell_ctrl_type                ctrl,
   input  wire logic [ccs_pkg::TAP_WIDTH-1:0]         up_taps,
   input  wire logic [ccs_pkg::TAP_WIDTH-1:0]         down_taps,
   input  wire logic                                  right_bit,
   output logic      [1:0]                            own_taps,
   output logic                                       result_bit
);

   logic left_ff,   left_in;
   logic centre_ff, centre_in;
   logic result_ff, result_in;

   logic [ccs_pkg::THRESHOLD_WIDTH-1:0] wall_count;

   assign wall_count = ccs_pkg::count_walls({up_taps, left_ff, centre_ff, right_bit, down_taps});

   always_comb begin
      left_in   = left_ff;
      centre_in = centre_ff;
      result_in = result_ff;
      // slide the window by one column
      if (ctrl.shift) begin
         left_in   = centre_ff;
         centre_in = right_bit;
      end
      if (ctrl.load_result) begin
         result_in = (wall_count >= ctrl.threshold);
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      centre_ff <= centre_in;
      result_ff <= result_in;
   end

   assign own_taps   = {left_ff, centre_ff};
   assign result_bit = result_ff;

endmodule

`default_nettype wire

// File: sv/ccs_checker.sv
// Port-level checks for the cave column step unit, bound to the top level.
`default_nettype none

module ccs_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [ccs_pkg::COLUMN_WIDTH-1:0]    rsp_next_column,
   input wire logic                                rsp_last
);

   // output empties after reset
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   // a stalled result holds
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_column) && $stable(rsp_last))
      else $error("stalled result changed");

   // a fresh result needs a column transfer in the cycle before
   a_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without a column transfer");

   // an empty output never blocks the input
   a_ready : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

endmodule

bind cave_ca_column_step_unit ccs_checker u_ccs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_next_column (rsp_next_column),
   .rsp_last        (rsp_last)
);

`default_nettype wire
